// ----- hw/rtl/assert_macros.svh -----
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert that a implies b in the same cycle
`define ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("assertion failed");
// assert that a implies b in the next cycle
`define ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// ----- hw/rtl/dsrd_pkg.sv -----
// ----------------------------------------------------------------------------
// dsrd_pkg
// Shared types and constants of the sample record decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package dsrd_pkg;
  localparam logic [3:0] K_TIME = 4'd0;
  localparam logic [3:0] K_VEND = 4'd1;
  localparam logic [3:0] K_TEMP = 4'd2;
  localparam logic [3:0] K_PRES = 4'd3;
  localparam logic [3:0] K_DEPTH = 4'd4;
  localparam logic [3:0] K_GAS = 4'd5;
  localparam logic [3:0] K_DECO = 4'd6;
  localparam logic [3:0] K_SURF = 4'd7;
  localparam logic [3:0] K_ERR = 4'd8;

  localparam logic [2:0] CFG_MODEL = 3'd0;
  localparam logic [2:0] CFG_MODE = 3'd1;
  localparam logic [2:0] CFG_INTV = 3'd2;
  localparam logic [2:0] CFG_TEMP = 3'd3;
  localparam logic [2:0] CFG_PRES = 3'd4;
  localparam logic [2:0] CFG_GAS = 3'd5;

  localparam logic [1:0] MODE_FREE = 2'd2;
  localparam logic [7:0] TYPE_TANK = 8'hAA;
  localparam logic [7:0] TYPE_SURF = 8'hBB;
  localparam logic [15:0] PRESS_NONE = 16'd10000;
  localparam logic [3:0] GAS_NONE = 4'hF;
  localparam logic [15:0] M_ONE = 16'h4250;
  localparam logic [15:0] M_ZEN = 16'h4441;
  localparam logic [15:0] M_TX = 16'h4542;

  // one result transaction
  typedef struct packed {
    logic [3:0]  kind;
    logic [23:0] value;
    logic [2:0]  tank;
    logic [7:0]  stop;
  } res_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;     // capture record, reload if flagged
    logic decode;   // compute emit list and next state
    logic divstart; // start surface division
    logic divstep;  // one quotient bit
    logic commit;   // write next state
    logic pop;      // advance result index
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic       is_empty;
    logic       is_surf;
    logic       div_done;
    logic [2:0] nres;
  } sts_t;

  // model group membership
  typedef struct packed {
    logic free_short, wide, no_press, t6, t3, t1, tpack, inv5, sgn5, sgn0;
    logic p10, p5, p16, mask, cs, sw34;
  } grp_t;

  function automatic grp_t model_groups(input logic [15:0] m);
    grp_t g;
    g.free_short = m == 16'h434D || m == 16'h4549 || m == 16'h4554;
    g.wide = m == 16'h434E || m == 16'h4449 || m == 16'h4451 || m == 16'h454B ||
             m == 16'h4542 || m == 16'h454C || m == 16'h4557;
    g.no_press = m == 16'h435A || m == 16'h4450 || m == 16'h4357 || m == 16'h4359 ||
                 m == 16'h445A || m == 16'h4441 || m == 16'h4344 || m == 16'h4446 ||
                 m == 16'h4345;
    g.t6 = m == 16'h4344 || m == 16'h4250 || m == 16'h4357 || m == 16'h4345 ||
           m == 16'h4441;
    g.t3 = m == 16'h4446 || m == 16'h4359 || m == 16'h435A || m == 16'h434E ||
           m == 16'h4449 || m == 16'h4451 || m == 16'h454B || m == 16'h445A;
    g.t1 = m == 16'h4450 || m == 16'h4542;
    g.tpack = m == 16'h4447 || m == 16'h4452 || m == 16'h444C || m == 16'h4456 ||
              m == 16'h4457;
    g.inv5 = m == 16'h444D || m == 16'h4548;
    g.sgn5 = m == 16'h444B || m == 16'h4545 || m == 16'h4546;
    g.sgn0 = m == 16'h4342 || m == 16'h4444 || m == 16'h4257 || m == 16'h4453 ||
             m == 16'h4443 || m == 16'h4350 || m == 16'h4458;
    g.p10 = m == 16'h434E || m == 16'h4449 || m == 16'h4451 || m == 16'h454B;
    g.p5 = m == 16'h4447 || m == 16'h4452 || m == 16'h444C || m == 16'h4456 ||
           m == 16'h4442 || m == 16'h4457 || m == 16'h444D || m == 16'h4548 ||
           m == 16'h4546;
    g.p16 = m == 16'h4542 || m == 16'h454C || m == 16'h4557;
    g.mask = m == 16'h4347 || m == 16'h4348;
    g.cs = m == 16'h454C || m == 16'h4557;
    g.sw34 = m == 16'h4342 || m == 16'h4257 || m == 16'h4453;
    return g;
  endfunction

  function automatic logic [7:0] bcd(input logic [7:0] x);
    return 8'({4'd0, x[7:4]} * 8'd10 + {4'd0, x[3:0]});
  endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/dsrd_ctrl.sv -----
// ----------------------------------------------------------------------------
// dsrd_ctrl
// Sequencer: load, decode, optional divide, then one result per cycle while out_stall is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dsrd_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic          out_stall_i,
  output logic               out_valid_o,
  output logic               out_last_o,
  output dsrd_pkg::cmd_t     cmd_o,
  input  wire dsrd_pkg::sts_t sts_i
);
  import dsrd_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DEC, S_DIV, S_OUT} state_e;
  state_e state_q;
  logic [2:0] idx_q;

  assign in_stall_o = state_q != S_IDLE;
  assign out_valid_o = state_q == S_OUT;
  assign out_last_o = idx_q == sts_i.nres - 3'd1;

  always_comb begin
    cmd_o = '0;
    cmd_o.load = state_q == S_IDLE && in_valid_i;
    cmd_o.decode = state_q == S_DEC;
    cmd_o.divstart = state_q == S_DEC;
    cmd_o.divstep = state_q == S_DIV;
    cmd_o.commit = state_q == S_OUT && !out_stall_i && out_last_o;
    cmd_o.pop = state_q == S_OUT && !out_stall_i;
  end

  // state and result index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_DEC;
        S_DEC: begin
          idx_q <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (sts_i.is_empty) state_q <= S_IDLE;
          else if (!sts_i.is_surf || sts_i.div_done) begin
            if (sts_i.nres == 3'd0) state_q <= S_IDLE;
            else state_q <= S_OUT;
          end
        end
        S_OUT: if (!out_stall_i) begin
          if (out_last_o) state_q <= S_IDLE;
          idx_q <= idx_q + 3'd1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/dsrd_dp.sv -----
// ----------------------------------------------------------------------------
// dsrd_dp
// Datapath: record capture, field decode, surface divider, running state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dsrd_dp #(
  parameter int RecordBytes = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire dsrd_pkg::cmd_t cmd_i,
  output dsrd_pkg::sts_t      sts_o,
  input  wire logic           start_i,
  input  wire logic [63:0]    rec_lo_i,
  input  wire logic [63:0]    rec_hi_i,
  input  wire logic [15:0]    model_i,
  input  wire logic [1:0]     mode_i,
  input  wire logic [5:0]     intv_i,
  input  wire logic [7:0]     itemp_i,
  input  wire logic [15:0]    ipres_i,
  input  wire logic [2:0]     ngas_i,
  output dsrd_pkg::res_t      res_o
);
  import dsrd_pkg::*;

  logic [7:0] b_q [16];
  logic start_q;
  logic [23:0] et_q; logic rc_q; logic [7:0] tmp_q; logic [15:0] prs_q;
  logic [2:0] tnk_q; logic pp_q; logic [3:0] pg_q;
  logic [23:0] et_n; logic rc_n; logic [7:0] tmp_n; logic [15:0] prs_n;
  logic [2:0] tnk_n; logic pp_n; logic [3:0] pg_n;
  res_t list_q [7];
  logic [2:0] nres_q, ridx_q;
  logic empty_q, surf_q;
  // divider
  logic [13:0] dividend_q, quo_q; logic [5:0] rem_q; logic [3:0] dcnt_q;
  logic busy_q;

  grp_t g;
  logic fr;
  assign g = model_groups(model_i);
  assign fr = mode_i == MODE_FREE;

  // capture record, bytes beyond the record size read as zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < 8; i++) begin
        b_q[i] <= (i < RecordBytes) ? rec_lo_i[i*8 +: 8] : 8'd0;
        b_q[i+8] <= (i + 8 < RecordBytes) ? rec_hi_i[i*8 +: 8] : 8'd0;
      end
      start_q <= start_i;
    end
  end

  // effective state after optional reload
  logic [23:0] et_e; logic rc_e; logic [7:0] tmp_e; logic [15:0] prs_e;
  logic [2:0] tnk_e; logic pp_e; logic [3:0] pg_e;
  always_comb begin
    if (start_q) begin
      et_e = '0; rc_e = 1'b1; tmp_e = fr ? 8'd0 : itemp_i; prs_e = ipres_i;
      tnk_e = '0; pp_e = !fr && !g.no_press && ipres_i != PRESS_NONE; pg_e = GAS_NONE;
    end else begin
      et_e = et_q; rc_e = rc_q; tmp_e = tmp_q; prs_e = prs_q;
      tnk_e = tnk_q; pp_e = pp_q; pg_e = pg_q;
    end
  end

  // decode
  logic [4:0] size;
  logic zs, os, emp;
  logic [7:0] typ;
  res_t lst [7];
  logic [2:0] n;
  logic [13:0] surfv;
  always_comb begin
    logic [7:0] t, d2, sg;
    logic [15:0] p;
    logic [15:0] dep;
    logic [2:0] gi;
    logic [15:0] dt;
    logic [7:0] st;
    logic have, err;
    size = fr ? (g.free_short ? 5'd2 : 5'd4) : (g.wide ? 5'd16 : 5'd8);
    zs = 1'b1; os = 1'b1;
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < size && i < RecordBytes) begin
        if (b_q[i] != 8'h00) zs = 1'b0;
        if (b_q[i] != 8'hFF) os = 1'b0;
      end
    end
    emp = (!fr && zs) || os;
    typ = fr ? 8'd0 : b_q[0];
    for (int i = 0; i < 7; i++) lst[i] = '0;
    n = '0;
    et_n = et_e; rc_n = rc_e; tmp_n = tmp_e; prs_n = prs_e;
    tnk_n = tnk_e; pp_n = pp_e; pg_n = pg_e;
    surfv = 14'({6'd0, bcd(b_q[1])} * 14'd60 + {6'd0, bcd(b_q[2])});
    t = '0; d2 = '0; sg = '0; p = '0; dep = '0; gi = '0; dt = '0; st = '0;
    have = 1'b0; err = 1'b0;
    if (rc_e) begin
      et_n = et_e + {18'd0, intv_i};
      lst[n] = '{K_TIME, et_n, 3'd0, 8'd0}; n = n + 3'd1;
      rc_n = 1'b0;
    end
    lst[n] = '{K_VEND, 24'd0, 3'd0, 8'd0}; n = n + 3'd1;
    if (typ == TYPE_TANK) begin
      if (g.mask) begin
        tnk_n = '0; prs_n = {4'd0, b_q[7][3:0], b_q[6]};
      end else if (g.cs) begin
        tnk_n = {1'b0, b_q[1][1:0]} + 3'd7; prs_n = {4'd0, b_q[7][3:0], b_q[6]};
      end else begin
        tnk_n = {1'b0, b_q[1][1:0]} + 3'd7;
        if (g.sw34) prs_n = {3'd0, b_q[3][3:0], b_q[4], 1'b0};
        else prs_n = {3'd0, b_q[4][3:0], b_q[5], 1'b0};
      end
    end else if (typ != TYPE_SURF) begin
      if (!fr) begin
        t = tmp_e;
        priority if (g.t6) t = b_q[6];
        else if (g.t3) t = b_q[3];
        else if (g.t1) t = b_q[1];
        else if (g.tpack) t = {b_q[5][3:2], b_q[7][3:2], b_q[7][7:4]};
        else if (g.cs) t = b_q[11];
        else begin
          d2 = {6'd0, b_q[7][3:2]};
          if (g.inv5) sg = {7'd0, ~b_q[5][2]};
          else if (g.sgn5) sg = {7'd0, b_q[5][2]};
          else if (g.sgn0) sg = {7'd0, b_q[0][7]};
          else sg = {7'd0, ~b_q[0][7]};
          t = sg[0] ? t - d2 : t + d2;
        end
        tmp_n = t;
        lst[n] = '{K_TEMP, {16'd0, t}, 3'd0, 8'd0}; n = n + 3'd1;
      end
      if (pp_e) begin
        p = prs_e;
        priority if (g.p10) p = {4'd0, b_q[11][3:0], b_q[10]};
        else if (g.p5) p = 16'({6'd0, b_q[0][1:0], b_q[1]} * 16'd5);
        else if (g.p16) p = {b_q[5], b_q[4]};
        else p = p - {8'd0, b_q[1]};
        prs_n = p;
        lst[n] = '{K_PRES, {8'd0, p}, tnk_e, 8'd0}; n = n + 3'd1;
      end
      priority if (fr) dep = {b_q[1], b_q[0]};
      else if (g.t3) dep = {4'd0, b_q[5][3:0], b_q[4]};
      else if (model_i == M_ONE) dep = {4'd0, b_q[3], 4'd0};
      else dep = {4'd0, b_q[3][3:0], b_q[2]};
      lst[n] = '{K_DEPTH, {8'd0, dep}, 3'd0, 8'd0}; n = n + 3'd1;
      if (model_i == M_TX) begin
        gi = b_q[0][2:0];
        if ({1'b0, gi} != pg_e) begin
          if (gi < 3'd1 || gi > ngas_i) begin
            lst[n] = '{K_ERR, {21'd0, gi}, 3'd0, 8'd0}; n = n + 3'd1;
            err = 1'b1;
          end else begin
            lst[n] = '{K_GAS, {21'd0, gi - 3'd1}, 3'd0, 8'd0}; n = n + 3'd1;
            pg_n = {1'b0, gi};
          end
        end
      end
      if (!err) begin
        have = 1'b1;
        if (g.cs) begin
          st = {5'd0, b_q[15][6:4]}; dt = {6'd0, b_q[7][1:0], b_q[6]};
        end else if (model_i == M_ZEN) begin
          st = {4'd0, b_q[5][7:4]}; dt = {4'd0, b_q[5][3:0], b_q[4]};
        end else if (model_i == M_TX) begin
          st = b_q[10]; dt = {b_q[7], b_q[6]};
        end else have = 1'b0;
        if (have) begin
          lst[n] = '{K_DECO, 24'({8'd0, dt} * 24'd60), 3'd0, st}; n = n + 3'd1;
        end
        rc_n = 1'b1;
      end
    end
  end

  // surface count result and time advance, after the divider
  logic [23:0] adv;
  assign adv = 24'({10'd0, quo_q - 14'd1} * {18'd0, intv_i});

  always_ff @(posedge clk_i) begin
    if (cmd_i.decode) begin
      for (int i = 0; i < 7; i++) list_q[i] <= lst[i];
      nres_q <= n;
      empty_q <= emp;
      surf_q <= typ == TYPE_SURF;
    end else if (surf_q && !busy_q && cmd_i.divstep && quo_q != 14'd0) begin
      list_q[nres_q] <= '{K_SURF, {10'd0, quo_q}, 3'd0, 8'd0};
      nres_q <= nres_q + 3'd1;
      surf_q <= 1'b0;
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [6:0] trial;
  assign trial = {rem_q, dividend_q[13]};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; dcnt_q <= '0; dividend_q <= '0; rem_q <= '0; quo_q <= '0;
    end else if (cmd_i.divstart) begin
      busy_q <= 1'b1; dcnt_q <= '0; dividend_q <= surfv; rem_q <= '0; quo_q <= '0;
    end else if (busy_q && cmd_i.divstep) begin
      if (intv_i == 6'd0) begin
        quo_q <= '0; busy_q <= 1'b0;
      end else begin
        dividend_q <= {dividend_q[12:0], 1'b0};
        if (trial >= {1'b0, intv_i}) begin
          rem_q <= 6'(trial - {1'b0, intv_i}); quo_q <= {quo_q[12:0], 1'b1};
        end else begin
          rem_q <= trial[5:0]; quo_q <= {quo_q[12:0], 1'b0};
        end
        dcnt_q <= dcnt_q + 4'd1;
        if (dcnt_q == 4'd13) busy_q <= 1'b0;
      end
    end
  end

  // captured next state per record
  logic [23:0] et_s; logic rc_s; logic [7:0] tmp_s; logic [15:0] prs_s;
  logic [2:0] tnk_s; logic pp_s; logic [3:0] pg_s;
  always_ff @(posedge clk_i) begin
    if (cmd_i.decode) begin
      et_s <= et_n; rc_s <= rc_n; tmp_s <= tmp_n; prs_s <= prs_n;
      tnk_s <= tnk_n; pp_s <= pp_n; pg_s <= pg_n;
    end else if (surf_q && !busy_q && cmd_i.divstep && quo_q != 14'd0) begin
      et_s <= et_s + adv; rc_s <= 1'b1;
    end
  end

  // running state; an empty record or zero surface count still honors reload
  logic fin;
  assign fin = cmd_i.divstep && (empty_q || ((!surf_q || !busy_q) && nres_q == 3'd0));
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      et_q <= '0; rc_q <= 1'b1; tmp_q <= '0; prs_q <= '0;
      tnk_q <= '0; pp_q <= 1'b1; pg_q <= GAS_NONE;
    end else if (cmd_i.commit) begin
      et_q <= et_s; rc_q <= rc_s; tmp_q <= tmp_s; prs_q <= prs_s;
      tnk_q <= tnk_s; pp_q <= pp_s; pg_q <= pg_s;
    end else if (fin && start_q) begin
      et_q <= et_e; rc_q <= rc_e; tmp_q <= tmp_e; prs_q <= prs_e;
      tnk_q <= tnk_e; pp_q <= pp_e; pg_q <= pg_e;
    end else if (cmd_i.divstep && surf_q && !busy_q && quo_q == 14'd0 && !empty_q) begin
      et_q <= et_s; rc_q <= rc_s; tmp_q <= tmp_s; prs_q <= prs_s;
      tnk_q <= tnk_s; pp_q <= pp_s; pg_q <= pg_s;
    end
  end

  // result index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ridx_q <= '0;
    else if (cmd_i.decode) ridx_q <= '0;
    else if (cmd_i.pop) ridx_q <= ridx_q + 3'd1;
  end

  assign res_o = list_q[ridx_q];
  assign sts_o.is_empty = empty_q;
  assign sts_o.is_surf = surf_q;
  assign sts_o.div_done = !busy_q && !cmd_i.decode;
  assign sts_o.nres = nres_q;
endmodule
`default_nettype wire

// ----- hw/rtl/dive_sample_record_decoder.sv -----
// ----------------------------------------------------------------------------
// dive_sample_record_decoder
// Decodes one 16-byte dive log sample record into up to seven results.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  start_dive, record_low, record_high
// out      output     out_valid/out_stall kind, value, tank, deco_stop, last
// cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A record passes through an accept, a decode and a status step, then its
// results (one to seven) are presented in turn; an empty record ends after
// the status step with no results. A surface-interval record holds the status
// step for a restoring divide (one quotient bit per cycle).
// One record is in flight at a time; out_stall holds the current result.
// No clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dive_sample_record_decoder #(
  parameter int RECORD_BYTES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        start_dive_i,
  input  wire logic [63:0] record_low_i,
  input  wire logic [63:0] record_high_i,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       kind_o,
  output logic [23:0]      value_o,
  output logic signed [2:0] tank_o,
  output logic [7:0]       deco_stop_o,
  output logic             last_o,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import dsrd_pkg::*;

  logic [15:0] model_q; logic [1:0] mode_q; logic [5:0] intv_q;
  logic [7:0] itemp_q; logic [15:0] ipres_q; logic [2:0] ngas_q;
  cmd_t cmd; sts_t sts; res_t res;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_q <= '0; mode_q <= '0; intv_q <= 6'd2;
      itemp_q <= '0; ipres_q <= '0; ngas_q <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MODEL: model_q <= cfg_data;
        CFG_MODE:  mode_q <= cfg_data[1:0];
        CFG_INTV:  intv_q <= cfg_data[5:0];
        CFG_TEMP:  itemp_q <= cfg_data[7:0];
        CFG_PRES:  ipres_q <= cfg_data;
        CFG_GAS:   ngas_q <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  dsrd_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_valid), .in_stall_o(in_stall),
    .out_stall_i(out_stall), .out_valid_o(out_valid), .out_last_o(last_o),
    .cmd_o(cmd), .sts_i(sts)
  );

  dsrd_dp #(.RecordBytes(RECORD_BYTES)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .start_i(start_dive_i), .rec_lo_i(record_low_i), .rec_hi_i(record_high_i),
    .model_i(model_q), .mode_i(mode_q), .intv_i(intv_q), .itemp_i(itemp_q),
    .ipres_i(ipres_q), .ngas_i(ngas_q), .res_o(res)
  );

  assign kind_o = res.kind;
  assign value_o = res.value;
  assign tank_o = res.tank;
  assign deco_stop_o = res.stop;

  `ASSERT_IMP(a_no_accept_busy, out_valid, in_stall)
  `ASSERT_NXT(a_last_ends, out_valid && !out_stall && last_o, !out_valid)
  `ASSERT_IMP(a_tank_only_pres, out_valid && kind_o != K_PRES, tank_o == 3'sd0)
endmodule
`default_nettype wire
